[src/rhb_pkg.sv]
// Shared types, constants and helpers for the rolling history buffer.
package rhb_pkg;

	localparam int DEPTH     = 64;
	localparam int ELEM_BITS = 32;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int MODE_W    = 2;
	localparam int WORD_W    = 32;
	localparam int AC_W      = 7;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W    = $clog2(QUEUE_DEPTH);

	localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BURST = 2'd2;
	localparam logic [MODE_W-1:0] MODE_FILL  = 2'd3;

	typedef logic [ELEM_BITS-1:0] elem_t;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_FILL,
		OP_ERR,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] addr;
		logic [AC_W-1:0]  count;
		logic             wraps;
		logic [AC_W-1:0]  depth;
		elem_t            value;
	} cmd_t;

	function automatic elem_t to_elem(input logic [WORD_W-1:0] w);
		logic [63:0] tmp;
		tmp = 64'(w);
		return tmp[ELEM_BITS-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] to_word(input elem_t e);
		logic [63:0] tmp;
		tmp = 64'(e);
		return tmp[WORD_W-1:0];
	endfunction

endpackage

[src/rhb_ram.sv]
// Generic single-port-write, registered-read RAM.
module rhb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/rhb_front.sv]
// Front end: takes requests, tracks position and depth, builds queue commands.
module rhb_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [rhb_pkg::AC_W-1:0]    cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [rhb_pkg::MODE_W-1:0]  mode,
	input  logic [rhb_pkg::WORD_W-1:0]  write_value,
	input  logic [rhb_pkg::AC_W-1:0]    age_or_count,
	input  logic                        q_full,
	output logic                        q_push,
	output rhb_pkg::cmd_t               q_cmd
);
	import rhb_pkg::*;

	logic [AC_W-1:0]  depth_q;
	logic [IDX_W-1:0] pos_q;
	logic [AC_W-1:0]  d;
	logic [AC_W-1:0]  pos_ext;
	logic [AC_W-1:0]  pos_inc;
	logic [AC_W-1:0]  nm1;
	logic [AC_W-1:0]  addr_ext;
	logic [IDX_W-1:0] nxt_pos;
	logic             wraps;
	logic             accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept;

	always_comb begin
		if (depth_q == '0) begin
			d = AC_W'(1);
		end else if (depth_q > AC_W'(DEPTH)) begin
			d = AC_W'(DEPTH);
		end else begin
			d = depth_q;
		end
		pos_ext  = AC_W'(pos_q);
		pos_inc  = pos_ext + AC_W'(1);
		nxt_pos  = (pos_inc >= d) ? '0 : pos_inc[IDX_W-1:0];
		nm1      = age_or_count - AC_W'(1);
		wraps    = 1'b0;
		addr_ext = '0;

		q_cmd.op    = OP_ERR;
		q_cmd.addr  = '0;
		q_cmd.count = AC_W'(1);
		q_cmd.wraps = 1'b0;
		q_cmd.depth = d;
		q_cmd.value = to_elem(write_value);

		case (mode)
			MODE_PUSH: begin
				q_cmd.op   = OP_WRITE;
				q_cmd.addr = nxt_pos;
			end
			MODE_FILL: begin
				q_cmd.op = OP_FILL;
			end
			MODE_READ: begin
				if (age_or_count < d) begin
					if (age_or_count > pos_ext) begin
						addr_ext = d - (age_or_count - pos_ext);
					end else begin
						addr_ext = pos_ext - age_or_count;
					end
					q_cmd.op   = OP_READ;
					q_cmd.addr = addr_ext[IDX_W-1:0];
				end
			end
			MODE_BURST: begin
				if (age_or_count != '0 && age_or_count <= d) begin
					wraps = nm1 > pos_ext;
					if (wraps) begin
						addr_ext = d - (nm1 - pos_ext);
					end else begin
						addr_ext = pos_ext - nm1;
					end
					q_cmd.op    = OP_READ;
					q_cmd.addr  = addr_ext[IDX_W-1:0];
					q_cmd.count = age_or_count;
					q_cmd.wraps = wraps;
				end
			end
			default: begin
				q_cmd.op = OP_ERR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= AC_W'(DEPTH);
			pos_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				depth_q <= cfg_wr_data;
			end
			if (accept && mode == MODE_PUSH) begin
				pos_q <= nxt_pos;
			end else if (accept && mode == MODE_FILL) begin
				pos_q <= '0;
			end
		end
	end

endmodule

[src/rhb_queue.sv]
// Short command queue between the front and back ends.
module rhb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rhb_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output rhb_pkg::cmd_t head_cmd
);
	import rhb_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

[src/rhb_back.sv]
// Back end: executes queued commands against the store and drives results.
module rhb_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  rhb_pkg::cmd_t               head_cmd,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        status,
	output logic [rhb_pkg::WORD_W-1:0]  read_value,
	output logic                        last
);
	import rhb_pkg::*;

	logic             busy_q;
	logic [IDX_W-1:0] cur_idx_q;
	logic [AC_W-1:0]  remain_q;
	logic [DEPTH-1:0] written_q;
	elem_t            fill_val_q;

	logic             v_s1;
	logic             status_s1;
	logic             last_s1;
	logic             rd_s1;
	logic             hit_s1;
	elem_t            fill_s1;

	logic             advance;
	logic             go;
	logic             is_read;
	logic             last_elem;
	logic [IDX_W-1:0] idx;
	logic [AC_W-1:0]  rem;
	logic [AC_W-1:0]  nxt_ext;
	logic [IDX_W-1:0] nxt_idx;
	elem_t            ram_rdata;

	assign advance   = !v_s1 || !out_stall;
	assign go        = head_valid && advance;
	assign is_read   = head_cmd.op == OP_READ;
	assign idx       = busy_q ? cur_idx_q : head_cmd.addr;
	assign rem       = busy_q ? remain_q : head_cmd.count;
	assign last_elem = !is_read || rem == AC_W'(1);
	assign pop       = go && last_elem;
	assign nxt_ext   = AC_W'(idx) + AC_W'(1);
	// wrap the burst index only when the run crosses the ring end
	assign nxt_idx   = (head_cmd.wraps && nxt_ext >= head_cmd.depth) ? '0 : nxt_ext[IDX_W-1:0];

	rhb_ram #(
		.WIDTH(ELEM_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (go && head_cmd.op == OP_WRITE),
		.waddr (head_cmd.addr),
		.wdata (head_cmd.value),
		.re    (go && is_read),
		.raddr (idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			cur_idx_q  <= '0;
			remain_q   <= '0;
			written_q  <= '0;
			fill_val_q <= '0;
			v_s1       <= 1'b0;
		end else begin
			if (advance) begin
				v_s1 <= go;
			end
			if (go && is_read) begin
				busy_q    <= !last_elem;
				cur_idx_q <= nxt_idx;
				remain_q  <= rem - AC_W'(1);
			end
			if (go && head_cmd.op == OP_WRITE) begin
				written_q[head_cmd.addr] <= 1'b1;
			end
			// an entry not written since the last fill reads as the fill value
			if (go && head_cmd.op == OP_FILL) begin
				written_q  <= '0;
				fill_val_q <= head_cmd.value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			status_s1 <= head_cmd.op == OP_ERR;
			last_s1   <= last_elem;
			rd_s1     <= is_read;
			hit_s1    <= written_q[idx];
			fill_s1   <= fill_val_q;
		end
	end

	assign out_valid  = v_s1;
	assign status     = status_s1;
	assign last       = last_s1;
	assign read_value = rd_s1 ? to_word(hit_s1 ? ram_rdata : fill_s1) : '0;

endmodule

[src/rolling_history_buffer_unit.sv]
// Top level of the rolling history buffer.
// A taken request enters the command queue; the back end executes it and registers its result.
// Throughput: one request per cycle for push, fill and single reads while no stall is
// raised; a burst of N holds the back end's store read port for N results, one per cycle.
// Reset: position 0, depth 64, store reads as zero through per-entry written bits;
// no clearing pass, requests are taken right after reset.
module rolling_history_buffer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [rhb_pkg::AC_W-1:0]    cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [rhb_pkg::MODE_W-1:0]  mode,
	input  logic [rhb_pkg::WORD_W-1:0]  write_value,
	input  logic [rhb_pkg::AC_W-1:0]    age_or_count,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        status,
	output logic [rhb_pkg::WORD_W-1:0]  read_value,
	output logic                        last
);
	import rhb_pkg::*;

	logic q_full;
	logic q_push;
	cmd_t q_cmd;
	logic q_pop;
	logic head_valid;
	cmd_t head_cmd;

	rhb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.write_value  (write_value),
		.age_or_count (age_or_count),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (q_cmd)
	);

	rhb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	rhb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.read_value (read_value),
		.last       (last)
	);

endmodule

[src/rhb_checker.sv]
// Port-level checks for the rolling history buffer, bound to the top level.
module rhb_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       status,
	input logic [rhb_pkg::WORD_W-1:0] read_value,
	input logic                       last
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(status)
			&& $stable(last))
		else $error("stalled result changed");

	// an error ends its request's results
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> last)
		else $error("error result not flagged last");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> read_value == '0)
		else $error("error result carries data");

	// advance a burst without gaps once a non-final result is taken
	a_burst_dense: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside a burst");

endmodule

bind rolling_history_buffer_unit rhb_checker u_rhb_checker (.*);

[verif/rolling_history_buffer_unit_tb.sv]
// Self-checking testbench for the rolling history buffer: directed table plus random phases.
`timescale 1ns / 100ps

module testbench;
	import rhb_pkg::*;

	typedef struct packed {
		logic              status;
		logic [WORD_W-1:0] value;
		logic              last;
	} history_result_t;

	typedef struct packed {
		logic [MODE_W-1:0] md;
		logic [WORD_W-1:0] wv;
		logic [AC_W-1:0]   ac;
		logic              typed;
		history_result_t   exp;
	} stim_row_t;

	localparam history_result_t RES_DONE   = '{1'b0, 32'h0, 1'b1};
	localparam history_result_t RES_BOUNDS = '{1'b1, 32'h0, 1'b1};
	localparam history_result_t RES_NONE   = '{1'b0, 32'h0, 1'b0};
	localparam int N_DIRECTED = 21;
	localparam int N_PHASES   = 9;
	localparam int PHASE_ITEMS = 20;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [AC_W-1:0]     cfg_wr_data;
	logic                in_valid;
	logic                in_stall;
	logic [MODE_W-1:0]   mode;
	logic [WORD_W-1:0]   write_value;
	logic [AC_W-1:0]     age_or_count;
	logic                out_valid;
	logic                out_stall;
	logic                status;
	logic [WORD_W-1:0]   read_value;
	logic                last;

	// predictor state
	logic [ELEM_BITS-1:0] model_store [DEPTH];
	logic [IDX_W-1:0]     model_pos;
	logic [AC_W-1:0]      model_depth;

	history_result_t history_due [$];
	int              fail_count;
	int              idle_pct;

	stim_row_t directed_rows [N_DIRECTED];
	int        depth_plan [N_PHASES];
	bit        fill_plan [N_PHASES];

	rolling_history_buffer_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.write_value (write_value),
		.age_or_count(age_or_count),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.read_value  (read_value),
		.last        (last)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < idle_pct);
	end

	function automatic int unsigned eff_depth();
		if (model_depth == 0)
			return 1;
		if (model_depth > DEPTH)
			return DEPTH;
		return 32'(model_depth);
	endfunction

	function automatic void add_due(input logic st, input logic [WORD_W-1:0] val,
			input logic lst, input bit record);
		if (record)
			history_due.push_back('{st, val, lst});
	endfunction

	// Advance the model by one request and queue the results it causes.
	function automatic void predict_history(input logic [MODE_W-1:0] md,
			input logic [WORD_W-1:0] wv, input logic [AC_W-1:0] ac, input bit record);
		int unsigned d;
		int unsigned pos;
		int unsigned idx;
		int unsigned n;
		bit wraps;
		d = eff_depth();
		pos = 32'(model_pos);
		case (md)
		MODE_PUSH: begin
			pos = pos + 1;
			if (pos >= d)
				pos = 0;
			model_pos = pos[IDX_W-1:0];
			model_store[pos % DEPTH] = wv[ELEM_BITS-1:0];
			add_due(1'b0, '0, 1'b1, record);
		end
		MODE_FILL: begin
			for (int i = 0; i < DEPTH; i++)
				model_store[i] = wv[ELEM_BITS-1:0];
			model_pos = '0;
			add_due(1'b0, '0, 1'b1, record);
		end
		MODE_READ: begin
			if (ac >= d) begin
				add_due(1'b1, '0, 1'b1, record);
			end else begin
				idx = (ac > pos) ? d - (ac - pos) : pos - ac;
				add_due(1'b0, model_store[idx % DEPTH], 1'b1, record);
			end
		end
		default: begin
			n = 32'(ac);
			if (n == 0 || n > d) begin
				add_due(1'b1, '0, 1'b1, record);
			end else begin
				wraps = (n - 1) > pos;
				idx = wraps ? d - (n - 1 - pos) : pos - (n - 1);
				for (int unsigned i = 0; i < n; i++) begin
					add_due(1'b0, model_store[idx % DEPTH], (i + 1 == n), record);
					idx++;
					if (wraps && idx >= d)
						idx = 0;
				end
			end
		end
		endcase
	endfunction

	// Present one request, hold it through stalls, update the model on acceptance.
	task automatic issue_request(input logic [MODE_W-1:0] md, input logic [WORD_W-1:0] wv,
			input logic [AC_W-1:0] ac, input bit typed, input history_result_t exp);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= md;
		write_value  <= wv;
		age_or_count <= ac;
		do
			@(posedge clk);
		while (in_stall);
		predict_history(md, wv, ac, !typed);
		if (typed)
			history_due.push_back(exp);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (history_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_depth(input logic [AC_W-1:0] d);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= d;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		model_depth = d;
	endtask

	task automatic random_request();
		int unsigned roll;
		int unsigned d;
		logic [MODE_W-1:0] md;
		logic [AC_W-1:0] ac;
		d = eff_depth();
		roll = $urandom_range(99);
		if (roll < 40)
			md = MODE_PUSH;
		else if (roll < 70)
			md = MODE_READ;
		else if (roll < 92)
			md = MODE_BURST;
		else
			md = MODE_FILL;
		if ($urandom_range(9) < 8) begin
			if (md == MODE_READ)
				ac = AC_W'($urandom_range(d - 1, 0));
			else if ($urandom_range(19) == 0)
				ac = AC_W'(d);
			else
				ac = AC_W'($urandom_range((d > 16) ? 16 : d, 1));
		end else begin
			ac = AC_W'($urandom_range(127, 0));
		end
		issue_request(md, $urandom(), ac, 1'b0, RES_NONE);
	endtask

	always @(posedge clk) begin
		history_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (history_due.size() == 0) begin
				if (fail_count < 10)
					$display("%0t: unexpected result: status %0d value %h last %0d",
						$time, status, read_value, last);
				fail_count++;
			end else begin
				want = history_due.pop_front();
				if (want.status !== status || want.value !== read_value
						|| want.last !== last) begin
					if (fail_count < 10)
						$display("%0t: mismatch: expected status %0d value %h last %0d",
							$time, want.status, want.value, want.last,
							", got status %0d value %h last %0d",
							status, read_value, last);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		in_valid     = 1'b0;
		mode         = MODE_PUSH;
		write_value  = '0;
		age_or_count = '0;
		out_stall    = 1'b0;
		fail_count   = 0;
		idle_pct     = 36;
		model_pos    = '0;
		model_depth  = AC_W'(DEPTH);
		for (int i = 0; i < DEPTH; i++)
			model_store[i] = '0;

		directed_rows = '{
			'{MODE_READ,  32'h0,        7'd0,   1'b1, RES_DONE},
			'{MODE_READ,  32'h0,        7'd63,  1'b1, RES_DONE},
			'{MODE_READ,  32'h0,        7'd64,  1'b1, RES_BOUNDS},
			'{MODE_READ,  32'h0,        7'd127, 1'b1, RES_BOUNDS},
			'{MODE_BURST, 32'h0,        7'd0,   1'b1, RES_BOUNDS},
			'{MODE_BURST, 32'h0,        7'd65,  1'b1, RES_BOUNDS},
			'{MODE_BURST, 32'h0,        7'd127, 1'b1, RES_BOUNDS},
			'{MODE_PUSH,  32'hFFFFFFFF, 7'd0,   1'b1, RES_DONE},
			'{MODE_PUSH,  32'h00000000, 7'd127, 1'b1, RES_DONE},
			'{MODE_PUSH,  32'hA5A5A5A5, 7'd0,   1'b1, RES_DONE},
			'{MODE_PUSH,  32'h5A5A5A5A, 7'd0,   1'b1, RES_DONE},
			'{MODE_READ,  32'h0,        7'd0,   1'b0, RES_NONE},
			'{MODE_READ,  32'hFFFFFFFF, 7'd5,   1'b0, RES_NONE},
			'{MODE_BURST, 32'h0,        7'd4,   1'b0, RES_NONE},
			'{MODE_BURST, 32'h0,        7'd6,   1'b0, RES_NONE},
			'{MODE_BURST, 32'h0,        7'd64,  1'b0, RES_NONE},
			'{MODE_FILL,  32'h12345678, 7'd0,   1'b1, RES_DONE},
			'{MODE_READ,  32'h0,        7'd10,  1'b0, RES_NONE},
			'{MODE_PUSH,  32'hDEADBEEF, 7'd0,   1'b1, RES_DONE},
			'{MODE_BURST, 32'h0,        7'd2,   1'b0, RES_NONE},
			'{MODE_READ,  32'h0,        7'd1,   1'b0, RES_NONE}
		};
		// depth 0 and 127 exercise clamping; skip the fill to keep a stale position
		depth_plan = '{1, 64, 0, 127, 3, 40, 6, 2, 1};
		fill_plan  = '{1, 1, 1, 1, 1, 0, 0, 1, 1};
		depth_plan[N_PHASES-1] = $urandom_range(64, 1);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r])
			issue_request(directed_rows[r].md, directed_rows[r].wv, directed_rows[r].ac,
				directed_rows[r].typed, directed_rows[r].exp);

		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			write_depth(AC_W'(depth_plan[p]));
			// run one phase without any idling on either side
			idle_pct = (p == 1) ? 0 : 36;
			if (fill_plan[p])
				issue_request(MODE_FILL, $urandom(), AC_W'($urandom_range(127, 0)), 1'b0,
					RES_NONE);
			repeat (PHASE_ITEMS) random_request();
		end

		drain();
		repeat (6) @(posedge clk);
		if (fail_count == 0 && history_due.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
